@@ rtl/dsm_pkg.sv @@
package dsm_pkg;

  // defaults for the top-level parameters
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_WIDTH_DEF  = 4096;

  // configuration register layout
  localparam int CFG_W      = 13;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // row counter is fixed by the height register limit
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;

  // control word handed from the front stage to the output stage
  typedef struct packed {
    logic valid;
    logic last;
    logic row_odd;
  } dsm_ctl_t;

endpackage

@@ rtl/dsm_cfg.sv @@
module dsm_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dsm_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [dsm_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [dsm_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output logic [dsm_pkg::CFG_W-1:0]            frame_width,
  output logic [dsm_pkg::CFG_W-1:0]            frame_height
);

  dsm_pkg::reg_index_t sel;
  logic                wr;

  assign sel    = dsm_pkg::reg_index_t'(paddr[2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= dsm_pkg::CFG_W'(1);
      frame_height <= dsm_pkg::CFG_W'(1);
    end else if (wr) begin
      case (sel)
        dsm_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[dsm_pkg::CFG_W-1:0];
        dsm_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[dsm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      dsm_pkg::REG_FRAME_WIDTH:  prdata = dsm_pkg::APB_DATA_W'(frame_width);
      dsm_pkg::REG_FRAME_HEIGHT: prdata = dsm_pkg::APB_DATA_W'(frame_height);
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ rtl/dsm_front.sv @@
module dsm_front #(
  parameter int PIXEL_BITS = dsm_pkg::PIXEL_BITS_DEF,
  parameter int MAX_WIDTH  = dsm_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dsm_pkg::CFG_W-1:0]  frame_width,
  input  logic [dsm_pkg::CFG_W-1:0]  frame_height,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [PIXEL_BITS-1:0]      pixel,
  input  logic                       next_ready,
  output dsm_pkg::dsm_ctl_t          ctl,
  output logic [PIXEL_BITS:0]        pair_q,
  output logic [PIXEL_BITS:0]        above_q
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int DIM_W      = ($clog2(MAX_WIDTH + 1) > dsm_pkg::CFG_W) ?
                              $clog2(MAX_WIDTH + 1) : dsm_pkg::CFG_W;
  localparam int HGT_W      = dsm_pkg::CFG_W;

  logic [PIXEL_BITS:0] line_mem [LINE_DEPTH];

  logic [COL_W-1:0]              col;
  logic [dsm_pkg::ROW_W-1:0]     row;
  logic [PIXEL_BITS-1:0]         left_pixel;

  logic [DIM_W-1:0]  w_raw, w_eff, col_inc;
  logic [HGT_W-1:0]  h_eff, row_inc;
  logic              last_col, last_row, have_pair, emit, wr_line, accept;
  logic [PIXEL_BITS:0] pair;
  logic [ADDR_W-1:0] k;

  // zero acts as one, oversize clamps to the limit
  always_comb begin
    w_raw = DIM_W'(frame_width);
    if (w_raw == '0)                        w_eff = DIM_W'(1);
    else if (w_raw > DIM_W'(MAX_WIDTH))     w_eff = DIM_W'(MAX_WIDTH);
    else                                    w_eff = w_raw;
    if (frame_height == '0)                             h_eff = HGT_W'(1);
    else if (frame_height > HGT_W'(dsm_pkg::MAX_HEIGHT)) h_eff = HGT_W'(dsm_pkg::MAX_HEIGHT);
    else                                                h_eff = frame_height;
  end

  assign col_inc  = DIM_W'(col) + DIM_W'(1);
  assign row_inc  = HGT_W'(row) + HGT_W'(1);
  assign last_col = col_inc >= w_eff;
  assign last_row = row_inc >= h_eff;

  assign pair = col[0] ? ((PIXEL_BITS+1)'(left_pixel) + (PIXEL_BITS+1)'(pixel))
                       : ((PIXEL_BITS+1)'(pixel) + (PIXEL_BITS+1)'(pixel));
  assign have_pair = col[0] | last_col;
  assign emit      = have_pair & (row[0] | last_row);
  assign wr_line   = have_pair & ~row[0] & ~last_row;
  assign k         = ADDR_W'(col >> 1);

  assign in_ready = ~ctl.valid | next_ready;
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      left_pixel <= '0;
      ctl        <= '0;
    end else begin
      if (in_ready) begin
        ctl.valid <= accept & emit;
      end
      if (accept) begin
        ctl.last    <= last_col & last_row;
        ctl.row_odd <= row[0];
        if (!have_pair) begin
          left_pixel <= pixel;
        end
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : dsm_pkg::ROW_W'(row_inc);
        end else begin
          col <= COL_W'(col_inc);
        end
      end
    end
  end

  // line buffer: even-row pair sums, read back by the odd row below
  always_ff @(posedge clk) begin
    if (accept) begin
      pair_q  <= pair;
      above_q <= line_mem[k];
      if (wr_line) begin
        line_mem[k] <= pair;
      end
    end
  end

endmodule

@@ rtl/dsm_out.sv @@
module dsm_out #(
  parameter int PIXEL_BITS = dsm_pkg::PIXEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dsm_pkg::dsm_ctl_t      ctl,
  input  logic [PIXEL_BITS:0]    pair_q,
  input  logic [PIXEL_BITS:0]    above_q,
  output logic                   ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIXEL_BITS-1:0]  pixel_out,
  output logic                   last_of_frame
);

  logic [PIXEL_BITS+1:0] sum;

  // odd row adds the pair above; a lone last even row counts itself twice
  assign sum   = ctl.row_odd ? ((PIXEL_BITS+2)'(above_q) + (PIXEL_BITS+2)'(pair_q))
                             : ((PIXEL_BITS+2)'(pair_q)  + (PIXEL_BITS+2)'(pair_q));
  assign ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && ctl.valid) begin
      pixel_out     <= sum[PIXEL_BITS+1:2];
      last_of_frame <= ctl.last;
    end
  end

endmodule

@@ rtl/downscale_2x2_mean.sv @@
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       s_tdata: pixel_in
// m_*      out  m_tvalid / m_tready       m_tdata: pixel_out, m_tlast: last_of_frame
// apb      in   psel / penable / pready   frame_width @0x0, frame_height @0x4
//
// One pixel per clock sustained while the output is not stalled. A pixel passes
// through the line buffer read register, then the output register. The line buffer
// sees one address per pixel (a read, plus a write on even-row pairs), which keeps
// that pace. rst is synchronous and clears counters and valid flags; the line
// buffer needs no clearing. A stalled output holds its data and backs pressure
// to s_tready in the same cycle.
module downscale_2x2_mean #(
  parameter int PIXEL_BITS = dsm_pkg::PIXEL_BITS_DEF,
  parameter int MAX_WIDTH  = dsm_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]        s_tdata,  // pixel_in
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]        m_tdata,  // pixel_out
  output logic                                   m_tlast,  // last_of_frame
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dsm_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [dsm_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [dsm_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;

  logic [dsm_pkg::CFG_W-1:0] frame_width, frame_height;
  dsm_pkg::dsm_ctl_t         ctl;
  logic [PIXEL_BITS:0]       pair_q, above_q;
  logic                      out_stage_ready;
  logic [PIXEL_BITS-1:0]     pixel_out;

  dsm_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  dsm_front #(
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .pixel        (s_tdata[PIXEL_BITS-1:0]),
    .next_ready   (out_stage_ready),
    .ctl          (ctl),
    .pair_q       (pair_q),
    .above_q      (above_q)
  );

  dsm_out #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .pair_q        (pair_q),
    .above_q       (above_q),
    .ready         (out_stage_ready),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .pixel_out     (pixel_out),
    .last_of_frame (m_tlast)
  );

  assign m_tdata = TDATA_W'(pixel_out);

endmodule

@@ dv/downscale_2x2_mean_tb.sv @@
module downscale_2x2_mean_tb;

  localparam int DATA_W          = ((dsm_pkg::PIXEL_BITS_DEF + 7) / 8) * 8;
  localparam int LINE_DEPTH      = dsm_pkg::MAX_WIDTH_DEF / 2;
  localparam int STALL_LIMIT     = 1000;
  localparam int ITEMS_PER_GROUP = 600;

  // one pixel request; known rows carry a hand-written expectation
  typedef struct packed {
    logic [15:0] pix;
    logic        known;
    logic [15:0] exp_pix;
    logic        exp_last;
  } pix_req_t;

  typedef struct packed {
    logic [15:0] pix;
    logic        last;
  } mean_t;

  typedef struct packed {
    logic [dsm_pkg::CFG_W-1:0] width;
    logic [dsm_pkg::CFG_W-1:0] height;
    pix_req_t                  req;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [23] = '{
    // 1x1 after reset: every pixel is its own frame
    '{13'd1, 13'd1, '{16'h0000, 1'b1, 16'h0000, 1'b1}},
    '{13'd1, 13'd1, '{16'hFFFF, 1'b1, 16'hFFFF, 1'b1}},
    '{13'd1, 13'd1, '{16'hAAAA, 1'b1, 16'hAAAA, 1'b1}},
    '{13'd1, 13'd1, '{16'h5555, 1'b1, 16'h5555, 1'b1}},
    // 2x2 full scale: largest exact sum
    '{13'd2, 13'd2, '{16'hFFFF, 1'b0, 16'h0000, 1'b0}},
    '{13'd2, 13'd2, '{16'hFFFF, 1'b0, 16'h0000, 1'b0}},
    '{13'd2, 13'd2, '{16'hFFFF, 1'b0, 16'h0000, 1'b0}},
    '{13'd2, 13'd2, '{16'hFFFF, 1'b1, 16'hFFFF, 1'b1}},
    // 2x2 sum of 3 truncates to 0
    '{13'd2, 13'd2, '{16'h0003, 1'b0, 16'h0000, 1'b0}},
    '{13'd2, 13'd2, '{16'h0000, 1'b0, 16'h0000, 1'b0}},
    '{13'd2, 13'd2, '{16'h0000, 1'b0, 16'h0000, 1'b0}},
    '{13'd2, 13'd2, '{16'h0000, 1'b1, 16'h0000, 1'b1}},
    // 3x3: odd last column and odd last row
    '{13'd3, 13'd3, '{16'h0001, 1'b0, 16'h0000, 1'b0}},
    '{13'd3, 13'd3, '{16'h0002, 1'b0, 16'h0000, 1'b0}},
    '{13'd3, 13'd3, '{16'h0003, 1'b0, 16'h0000, 1'b0}},
    '{13'd3, 13'd3, '{16'h0004, 1'b0, 16'h0000, 1'b0}},
    '{13'd3, 13'd3, '{16'h0005, 1'b0, 16'h0000, 1'b0}},
    '{13'd3, 13'd3, '{16'h0006, 1'b0, 16'h0000, 1'b0}},
    '{13'd3, 13'd3, '{16'h0007, 1'b0, 16'h0000, 1'b0}},
    '{13'd3, 13'd3, '{16'h0008, 1'b0, 16'h0000, 1'b0}},
    '{13'd3, 13'd3, '{16'hFFFF, 1'b0, 16'h0000, 1'b0}},
    // width 0 acts as 1: (2*1 + 2*2) / 4
    '{13'd0, 13'd2, '{16'h0001, 1'b0, 16'h0000, 1'b0}},
    '{13'd0, 13'd2, '{16'h0002, 1'b1, 16'h0001, 1'b1}}
  };

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [DATA_W-1:0]              s_tdata  = '0;   // pixel_in
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [DATA_W-1:0]              m_tdata;         // pixel_out
  logic                           m_tlast;         // last_of_frame
  logic                           psel     = 1'b0;
  logic                           penable  = 1'b0;
  logic                           pwrite   = 1'b0;
  logic [dsm_pkg::APB_ADDR_W-1:0] paddr    = '0;
  logic [dsm_pkg::APB_DATA_W-1:0] pwdata   = '0;
  logic [dsm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // downscaler state mirror
  logic [16:0]               pair_line [LINE_DEPTH];
  logic [15:0]               left_pix   = '0;
  int unsigned               col_cnt    = 0;
  int unsigned               row_cnt    = 0;
  logic [dsm_pkg::CFG_W-1:0] cfg_width  = 13'd1;
  logic [dsm_pkg::CFG_W-1:0] cfg_height = 13'd1;

  pix_req_t pix_q [$];
  mean_t    mean_q [$];
  pix_req_t cur_req = '0;
  int       err_cnt = 0;
  int       stall_cycles = 0;
  int       src_idle_pct = 18;
  int       snk_idle_pct = 64;

  downscale_2x2_mean DUT (.*);

  always #10 clk = ~clk;

  function automatic int unsigned eff_dim(input logic [dsm_pkg::CFG_W-1:0] v,
                                          input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // returns 1 when this pixel completes a 2x2 block
  function automatic bit downscale_pixel(input logic [15:0] pix, output mean_t res);
    int unsigned w, h, k;
    bit          last_col, last_row, have_pair, emit;
    logic [16:0] pair;
    logic [17:0] sum;
    w         = eff_dim(cfg_width, dsm_pkg::MAX_WIDTH_DEF);
    h         = eff_dim(cfg_height, dsm_pkg::MAX_HEIGHT);
    last_col  = (col_cnt + 1) >= w;
    last_row  = (row_cnt + 1) >= h;
    k         = col_cnt >> 1;
    have_pair = 1'b1;
    emit      = 1'b0;
    pair      = '0;
    sum       = '0;
    res       = '0;
    if (col_cnt[0]) begin
      pair = left_pix + pix;
    end else if (last_col) begin
      pair = pix + pix;
    end else begin
      left_pix  = pix;
      have_pair = 1'b0;
    end
    if (have_pair) begin
      if (row_cnt[0]) begin
        sum  = pair_line[k] + pair;
        emit = 1'b1;
      end else if (last_row) begin
        sum  = pair + pair;
        emit = 1'b1;
      end else begin
        pair_line[k] = pair;
      end
    end
    if (emit) begin
      res.pix  = sum[17:2];
      res.last = last_col && last_row;
    end
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return emit;
  endfunction

  // output check first, then input accept, so a result never races its prediction
  always @(posedge clk) begin : stream_proc
    mean_t want, got;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.pix  = m_tdata[15:0];
        got.last = m_tlast;
        if (mean_q.size() == 0) begin
          $error("unexpected result: pixel_out=%h last_of_frame=%b", got.pix, got.last);
          err_cnt++;
        end else begin
          want = mean_q.pop_front();
          if (got.pix !== want.pix) begin
            $error("pixel_out: expected %h, got %h", want.pix, got.pix);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last_of_frame: expected %b, got %b", want.last, got.last);
            err_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (downscale_pixel(cur_req.pix, want)) begin
          if (cur_req.known) begin
            want.pix  = cur_req.exp_pix;
            want.last = cur_req.exp_last;
          end
          mean_q.insert(mean_q.size(), want);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (pix_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_req = pix_q.pop_front();
          s_tdata  <= cur_req.pix;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog: cycles without any request moving on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[downscale_2x2_mean] ERROR");
      $finish;
    end
  end

  task automatic apb_xfer(input bit wr, input dsm_pkg::reg_index_t idx,
                          input logic [dsm_pkg::APB_DATA_W-1:0] wdata,
                          output logic [dsm_pkg::APB_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write with junk in the unused upper bits, then read back
  task automatic set_reg(input dsm_pkg::reg_index_t idx,
                         input logic [dsm_pkg::CFG_W-1:0] val);
    logic [dsm_pkg::APB_DATA_W-1:0] wd, rd;
    wd                     = $urandom;
    wd[dsm_pkg::CFG_W-1:0] = val;
    apb_xfer(1'b1, idx, wd, rd);
    if (idx == dsm_pkg::REG_FRAME_WIDTH) cfg_width = val;
    else cfg_height = val;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== {{(dsm_pkg::APB_DATA_W-dsm_pkg::CFG_W){1'b0}}, val}) begin
      $error("%s readback: expected %h, got %h", idx.name(), val, rd);
      err_cnt++;
    end
  endtask

  // all pixels sent, all results back, pipeline drained
  task automatic settle;
    do @(negedge clk); while (pix_q.size() != 0 || s_tvalid || mean_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_frames(input logic [dsm_pkg::CFG_W-1:0] w,
                            input logic [dsm_pkg::CFG_W-1:0] h,
                            input int frames, inout int sent);
    int unsigned n;
    pix_req_t    req;
    settle();
    set_reg(dsm_pkg::REG_FRAME_WIDTH, w);
    set_reg(dsm_pkg::REG_FRAME_HEIGHT, h);
    n = eff_dim(w, dsm_pkg::MAX_WIDTH_DEF) * eff_dim(h, dsm_pkg::MAX_HEIGHT) * frames;
    @(negedge clk);
    repeat (n) begin
      req = '0;
      case ($urandom_range(9))
        0: req.pix = '0;
        1: req.pix = '1;
        default: req.pix = $urandom;
      endcase
      pix_q.insert(pix_q.size(), req);
    end
    sent += n;
  endtask

  initial begin
    int                        sent;
    logic [dsm_pkg::CFG_W-1:0] w, h;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < $size(DIR_TAB); i++) begin
      if (DIR_TAB[i].width != cfg_width || DIR_TAB[i].height != cfg_height) begin
        settle();
        set_reg(dsm_pkg::REG_FRAME_WIDTH, DIR_TAB[i].width);
        set_reg(dsm_pkg::REG_FRAME_HEIGHT, DIR_TAB[i].height);
        @(negedge clk);
      end
      pix_q.insert(pix_q.size(), DIR_TAB[i].req);
    end

    // receiver-idle group, sender-idle group, then full rate
    for (int g = 0; g < 3; g++) begin
      src_idle_pct = (g == 0) ? 18 : (g == 1) ? 64 : 0;
      snk_idle_pct = (g == 0) ? 64 : (g == 1) ? 18 : 0;
      sent = 0;
      while (sent < ITEMS_PER_GROUP) begin
        case ($urandom_range(9))
          0: w = '0;
          1: w = 13'd1;
          2: w = 13'd2;
          9: w = $urandom_range(17, 64);
          default: w = $urandom_range(3, 16);
        endcase
        case ($urandom_range(7))
          0: h = '0;
          1: h = 13'd1;
          7: h = $urandom_range(9, 24);
          default: h = $urandom_range(2, 8);
        endcase
        run_frames(w, h, $urandom_range(1, 3), sent);
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("[downscale_2x2_mean] OK");
    end else begin
      $display("[downscale_2x2_mean] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dsm_pkg.sv
rtl/dsm_cfg.sv
rtl/dsm_front.sv
rtl/dsm_out.sv
rtl/downscale_2x2_mean.sv
dv/downscale_2x2_mean_tb.sv
